// File: src/ljs_pkg.sv
package ljs_pkg;

    localparam int LJS_STACK_DEPTH = 256;
    localparam int LJS_FIELD_W     = 16;

    typedef struct packed {
        logic                   arrival_valid;
        logic [LJS_FIELD_W-1:0] job_id;
        logic [LJS_FIELD_W-1:0] service_need;
    } t_in_item;

    typedef struct packed {
        logic                   served_valid;
        logic [LJS_FIELD_W-1:0] served_id;
        logic [LJS_FIELD_W-1:0] remaining_before;
        logic                   arrival_dropped;
    } t_out_item;

    typedef struct packed {
        logic latch_in;
        logic push;
        logic set_top;
        logic pop;
        logic load_cur;
        logic serve;
        logic idle_res;
    } t_ljs_cmd;

    typedef struct packed {
        logic unfinished_nz;
        logic cur_runnable;
        logic fill_zero;
        logic cur_is_top;
    } t_ljs_status;

endpackage

// File: src/ljs_ram.sv
module ljs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/ljs_ctrl.sv
module ljs_ctrl
    import ljs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_ljs_status i_status,
    output t_ljs_cmd    o_cmd,
    output logic        busy,
    output logic        o_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_CHECK,
        S_WAIT,
        S_SERVE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_done, n_done;
    t_ljs_cmd cmd;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_done  = 1'b0;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.latch_in = 1'b1;
                    n_state      = S_PUSH;
                    n_busy       = 1'b1;
                end
            end
            S_PUSH: begin
                cmd.push = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                priority if (!i_status.unfinished_nz || (!i_status.cur_runnable
                                                         && i_status.fill_zero)) begin
                    cmd.idle_res = 1'b1;
                    n_state      = S_IDLE;
                    n_busy       = 1'b0;
                    n_done       = 1'b1;
                end else if (i_status.cur_runnable) begin
                    n_state = S_SERVE;
                end else if (!i_status.cur_is_top) begin
                    cmd.set_top = 1'b1;
                    n_state     = S_WAIT;
                end else begin
                    cmd.pop = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                cmd.load_cur = 1'b1;
                n_state      = S_CHECK;
            end
            S_SERVE: begin
                cmd.serve = 1'b1;
                n_state   = S_IDLE;
                n_busy    = 1'b0;
                n_done    = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign o_cmd  = cmd;
    assign busy   = r_busy;
    assign o_done = r_done;

endmodule

// File: src/ljs_datapath.sv
module ljs_datapath
    import ljs_pkg::*;
#(
    parameter int STACK_DEPTH = LJS_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_item,
    input  t_ljs_cmd    i_cmd,
    output t_ljs_status o_status,
    output t_out_item   o_result
);

    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W  = $clog2(STACK_DEPTH);
    localparam int ENT_W  = 2 * LJS_FIELD_W;

    t_in_item  r_in;
    t_out_item r_result;
    logic      r_dropped;
    logic [LJS_FIELD_W-1:0] r_cur_id;
    logic [LJS_FIELD_W-1:0] r_cur_rem;
    logic [FILL_W-1:0] r_fill, r_cur, r_unfin;

    logic [FILL_W-1:0] fill_m1, fill_m2, cur_m1;
    logic              full, do_push;
    logic [LJS_FIELD_W-1:0] rem_dec;
    logic              wr_en, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [ENT_W-1:0]  wr_data, rd_data;

    assign fill_m1 = r_fill - FILL_W'(1);
    assign fill_m2 = r_fill - FILL_W'(2);
    assign cur_m1  = r_cur - FILL_W'(1);
    assign full    = (r_fill == FILL_W'(STACK_DEPTH));
    assign do_push = i_cmd.push && r_in.arrival_valid && !full;
    assign rem_dec = r_cur_rem - LJS_FIELD_W'(1);

    assign wr_en   = do_push || i_cmd.serve;
    assign wr_addr = do_push ? r_fill[IDX_W-1:0] : cur_m1[IDX_W-1:0];
    assign wr_data = do_push ? {r_in.job_id, r_in.service_need} : {r_cur_id, rem_dec};
    assign rd_en   = i_cmd.set_top || i_cmd.pop;
    assign rd_addr = i_cmd.pop ? fill_m2[IDX_W-1:0] : fill_m1[IDX_W-1:0];

    ljs_ram #(
        .WIDTH(ENT_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_cur   <= '0;
            r_unfin <= '0;
        end else begin
            if (do_push) begin
                r_fill <= r_fill + FILL_W'(1);
                if (r_in.service_need != '0) begin
                    r_unfin <= r_unfin + FILL_W'(1);
                end
            end
            if (i_cmd.set_top) begin
                r_cur <= r_fill;
            end
            if (i_cmd.pop) begin
                r_fill <= fill_m1;
                r_cur  <= fill_m1;
            end
            if (i_cmd.serve && r_cur_rem == LJS_FIELD_W'(1)) begin
                r_unfin <= r_unfin - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in <= i_item;
        end
        if (i_cmd.push) begin
            r_dropped <= r_in.arrival_valid && full;
        end
        if (i_cmd.load_cur) begin
            r_cur_id  <= rd_data[ENT_W-1:LJS_FIELD_W];
            r_cur_rem <= rd_data[LJS_FIELD_W-1:0];
        end
        if (i_cmd.serve) begin
            r_cur_rem                 <= rem_dec;
            r_result.served_valid     <= 1'b1;
            r_result.served_id        <= r_cur_id;
            r_result.remaining_before <= r_cur_rem;
            r_result.arrival_dropped  <= r_dropped;
        end
        if (i_cmd.idle_res) begin
            r_result.served_valid     <= 1'b0;
            r_result.served_id        <= '0;
            r_result.remaining_before <= '0;
            r_result.arrival_dropped  <= r_dropped;
        end
    end

    assign o_status.unfinished_nz = (r_unfin != '0);
    assign o_status.cur_runnable  = (r_cur != '0) && (r_cur_rem != '0);
    assign o_status.fill_zero     = (r_fill == '0);
    assign o_status.cur_is_top    = (r_cur == r_fill);
    assign o_result               = r_result;

endmodule

// File: src/lifo_job_scheduler.sv
// Each transfer on the input side is one scheduler tick. A tick is accepted when start is high
// and busy is low, and its single result appears on o_result for one cycle with o_done high; it
// cannot be held off and must be taken in that cycle. When the job in service keeps the server, a
// tick runs through arrival push, check, serve and the result cycle, in which the next tick can
// already be accepted. Each move of service to the stack top, and each pop of a finished top
// entry, adds a wait step and another check, because the stack lives in a single-port-read RAM
// with registered read data. No clearing pass is needed after reset.
module lifo_job_scheduler
    import ljs_pkg::*;
#(
    parameter int STACK_DEPTH = LJS_STACK_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_done,
    output t_out_item o_result
);

    t_ljs_cmd    cmd;
    t_ljs_status status;

    ljs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_status(status),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    ljs_datapath #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .o_status(status),
        .o_result(o_result)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("Accepted tick did not raise busy.");

    a_served_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.served_valid) |-> (o_result.remaining_before != '0))
        else $error("Served job had no remaining service.");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.served_valid) |->
            (o_result.served_id == '0 && o_result.remaining_before == '0))
        else $error("Idle result carries job data.");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("Result delivered while still busy.");

endmodule
